[sv/ttrc_pkg.sv]
`timescale 1ns / 1ps

package ttrc_pkg;

	localparam int unsigned TermWidth = 16;
	localparam int unsigned PosWidth  = 8;
	localparam int unsigned ProdWidth = 25;

	localparam logic [TermWidth-1:0] Modulus    = 16'hFFFF;
	localparam logic [TermWidth-1:0] TermReset  = 16'd1;
	localparam logic [7:0]           FirstAdd   = 8'd7;
	localparam logic [4:0]           AlphaMul   = 5'd17;
	localparam logic [4:0]           BetaMul    = 5'd31;

	typedef struct packed {
		logic [TermWidth-1:0] older_term;
		logic [TermWidth-1:0] newer_term;
		logic [PosWidth-1:0]  position;
		logic                 first_pending;
	} ttrc_state_t;

	localparam ttrc_state_t StateReset = '{
		older_term:    TermReset,
		newer_term:    TermReset,
		position:      '0,
		first_pending: 1'b1
	};

endpackage

[sv/ttrc_in_if.sv]
`timescale 1ns / 1ps

interface ttrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

[sv/ttrc_out_if.sv]
`timescale 1ns / 1ps

interface ttrc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum;

	modport source (output valid, output checksum, input ready);
	modport sink (input valid, input checksum, output ready);
endinterface

[sv/ttrc_term.sv]
`timescale 1ns / 1ps

module ttrc_term (
	input  ttrc_pkg::ttrc_state_t cur,
	input  logic [7:0]            data_byte,
	output ttrc_pkg::ttrc_state_t nxt
);

	logic [12:0] alpha_full;
	logic [12:0] beta_full;
	logic [7:0]  alpha;
	logic [7:0]  beta;
	logic [8:0]  coef;
	logic [ttrc_pkg::ProdWidth-1:0] prod;
	logic [ttrc_pkg::ProdWidth-1:0] sub;
	logic [ttrc_pkg::ProdWidth-1:0] diff;
	logic        neg;
	logic [16:0] fold;
	logic [15:0] red;
	logic [15:0] term;

	assign alpha_full = {5'd0, cur.position} * {8'd0, ttrc_pkg::AlphaMul};
	assign beta_full  = {5'd0, cur.position} * {8'd0, ttrc_pkg::BetaMul};
	assign alpha = alpha_full[7:0];
	assign beta  = beta_full[7:0];
	assign coef  = {1'b0, data_byte} + {1'b0, alpha};

	assign prod = {16'd0, coef} * {9'd0, cur.newer_term};
	assign sub  = {17'd0, beta} * {9'd0, cur.older_term};

	// magnitude of the difference, sign kept apart
	assign neg  = sub > prod;
	assign diff = neg ? (sub - prod) : (prod - sub);

	// 2^16 is 1 mod 65535: fold high part onto low part
	assign fold = {8'd0, diff[24:16]} + {1'b0, diff[15:0]};
	assign red  = (fold >= {1'b0, ttrc_pkg::Modulus}) ?
		16'(fold - {1'b0, ttrc_pkg::Modulus}) : fold[15:0];

	// negative difference wraps in 64 bits, giving 1 - red mod 65535
	always_comb begin
		if (!neg) begin
			term = red;
		end else if (red <= 16'd1) begin
			term = 16'd1 - red;
		end else begin
			term = 16'(17'h10000 - {1'b0, red});
		end
	end

	always_comb begin
		if (cur.first_pending) begin
			nxt.older_term    = ttrc_pkg::TermReset;
			nxt.newer_term    = {8'd0, data_byte} + {8'd0, ttrc_pkg::FirstAdd};
			nxt.position      = 8'd1;
			nxt.first_pending = 1'b0;
		end else begin
			nxt.older_term    = cur.newer_term;
			nxt.newer_term    = term;
			nxt.position      = cur.position + 8'd1;
			nxt.first_pending = 1'b0;
		end
	end

endmodule

[sv/three_term_recurrence_checksum_core.sv]
`timescale 1ns / 1ps

// Checksum over a byte stream: one byte is accepted per cycle, the last flag closing a
// message; each message's 16-bit checksum is loaded into the output register when its last
// byte leaves the input register. The input register feeds the term unit (four multiplies
// and an end-around fold mod 65535) whose result updates the recurrence state in the same
// cycle, so a new byte is taken every cycle; input ready drops only while a finished
// checksum waits in the output register and the byte held is the last of the next message.
module three_term_recurrence_checksum_core (
	input  logic          clk,
	input  logic          arst_n,
	ttrc_in_if.sink       msg,
	ttrc_out_if.source    result
);

	logic                  valid_s1;
	logic [7:0]            data_byte_s1;
	logic                  last_s1;
	ttrc_pkg::ttrc_state_t state_q;
	ttrc_pkg::ttrc_state_t state_nxt;
	logic                  out_valid_q;
	logic [15:0]           checksum_q;
	logic                  adv;

	ttrc_term u_term (
		.cur       (state_q),
		.data_byte (data_byte_s1),
		.nxt       (state_nxt)
	);

	assign adv       = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign msg.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			data_byte_s1 <= msg.data_byte;
			last_s1      <= msg.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttrc_pkg::StateReset;
		end else if (adv) begin
			state_q <= last_s1 ? ttrc_pkg::StateReset : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			checksum_q <= state_nxt.newer_term;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.checksum = checksum_q;

`ifndef SYNTH
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (state_q.first_pending && state_q.position == 8'd0))
		else $error("state not returned to reset after last item");

	a_checksum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (checksum_q != ttrc_pkg::Modulus))
		else $error("checksum out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!msg.ready |-> (valid_s1 && last_s1 && out_valid_q && !result.ready))
		else $error("input stalled without a waiting checksum");

	a_position_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !last_s1 && !state_q.first_pending) |=>
		(state_q.position == 8'($past(state_q.position) + 8'd1)))
		else $error("position did not advance");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

	typedef longint unsigned u64_t;

	typedef struct {
		logic [7:0] data_byte;
		logic       last;
		bit         drain;
	} byte_item_t;

	typedef enum {RxOpen, RxMostly, RxToggle, RxCoin} rx_mode_t;

	localparam int IdleLimit = 2000;
	localparam int HoldCycles = 400;
	localparam int HoldAfter = 150;
	localparam int RandomBytes = 700;

	logic clk = 1'b0;
	logic arst_n;

	ttrc_in_if  msg_if ();
	ttrc_out_if res_if ();

	three_term_recurrence_checksum_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.result (res_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	byte_item_t  tx_bytes[$];
	byte_item_t  next_byte;
	logic [15:0] expected_sums[$];
	ttrc_pkg::ttrc_state_t rec;

	int sums_pushed = 0;
	int sums_seen = 0;
	int bytes_taken = 0;
	int msgs_closed = 0;
	int neg_folds = 0;
	int pos_wraps = 0;
	int in_stalls = 0;
	int err_cnt = 0;
	int idle_cycles = 0;
	int gap_left = 0;
	int burst_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int seg_left = 0;
	rx_mode_t rx_mode = RxOpen;

	task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
		$display("mismatch: %s, expected %h, got %h at %0t", what, want, got, $realtime);
		err_cnt++;
	endtask

	task automatic add_byte(input logic [7:0] b, input logic fin, input bit drain);
		byte_item_t it;
		it.data_byte = b;
		it.last = fin;
		it.drain = drain;
		tx_bytes.push_back(it);
	endtask

	// recurrence: t = ((byte + alpha) * newer - beta * older) mod 65535, 64-bit wrap on borrow
	task automatic advance_recurrence(input logic [7:0] b, input logic fin);
		u64_t m;
		u64_t alpha;
		u64_t beta;
		u64_t prod;
		u64_t sub;
		u64_t d;
		logic [15:0] term;
		m = u64_t'(ttrc_pkg::Modulus);
		if (rec.first_pending) begin
			rec.older_term = ttrc_pkg::TermReset;
			rec.newer_term = 16'(b) + 16'(ttrc_pkg::FirstAdd);
			rec.position = 8'd1;
			rec.first_pending = 1'b0;
		end else begin
			alpha = (u64_t'(rec.position) * u64_t'(ttrc_pkg::AlphaMul)) % 256;
			beta = (u64_t'(rec.position) * u64_t'(ttrc_pkg::BetaMul)) % 256;
			prod = (u64_t'(b) + alpha) * u64_t'(rec.newer_term);
			sub = beta * u64_t'(rec.older_term);
			if (prod >= sub) begin
				term = 16'((prod - sub) % m);
			end else begin
				d = (sub - prod) % m;
				term = 16'((m + 1 - d) % m);
				neg_folds++;
			end
			rec.older_term = rec.newer_term;
			rec.newer_term = term;
			rec.position = rec.position + 8'd1;
			if (rec.position == '0) begin
				pos_wraps++;
			end
		end
		if (fin) begin
			expected_sums.push_back(rec.newer_term);
			sums_pushed++;
			msgs_closed++;
			rec = ttrc_pkg::StateReset;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_if.valid <= 1'b0;
			msg_if.data_byte <= '0;
			msg_if.last <= 1'b0;
		end else begin
			if (msg_if.valid && msg_if.ready) begin
				advance_recurrence(msg_if.data_byte, msg_if.last);
				bytes_taken <= bytes_taken + 1;
			end
			if (msg_if.valid && !msg_if.ready) begin
				in_stalls++;
			end
			if (!msg_if.valid || msg_if.ready) begin
				if (gap_left > 0 && hold_left == 0) begin
					gap_left--;
					msg_if.valid <= 1'b0;
				end else if (tx_bytes.size() > 0 &&
						(!tx_bytes[0].drain || sums_pushed == sums_seen)) begin
					next_byte = tx_bytes.pop_front();
					msg_if.valid <= 1'b1;
					msg_if.data_byte <= next_byte.data_byte;
					msg_if.last <= next_byte.last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					msg_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_if.ready <= 1'b0;
		end else if (!hold_done && msg_if.valid && bytes_taken >= HoldAfter) begin
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
			res_if.ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 80);
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			end else begin
				seg_left--;
			end
			case (rx_mode)
				RxOpen: res_if.ready <= 1'b1;
				RxMostly: res_if.ready <= ($urandom_range(0, 3) != 0);
				RxToggle: res_if.ready <= !res_if.ready;
				default: res_if.ready <= $urandom_range(0, 1);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_sums.size() == 0) begin
				report("checksum with no message pending", '0, res_if.checksum);
			end else if (res_if.checksum !== expected_sums[0]) begin
				report("checksum", expected_sums[0], res_if.checksum);
				void'(expected_sums.pop_front());
			end else begin
				void'(expected_sums.pop_front());
			end
			sums_seen <= sums_seen + 1;
		end
	end

	always @(posedge clk) begin
		if ((msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("timeout: no item moved for %0d cycles", IdleLimit);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int n;
		int len;
		int r;
		bit long_done;
		logic [7:0] b;
		msg_if.valid = 1'b0;
		msg_if.data_byte = '0;
		msg_if.last = 1'b0;
		res_if.ready = 1'b0;
		arst_n = 1'b0;
		rec = ttrc_pkg::StateReset;

		// one- and two-byte messages at both extremes, then an alternating 00/FF and an all-zero message
		add_byte(8'h00, 1'b1, 1'b0);
		add_byte(8'hFF, 1'b1, 1'b0);
		add_byte(8'hFF, 1'b0, 1'b0);
		add_byte(8'hFF, 1'b1, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'h00, 1'b1, 1'b0);
		for (int k = 0; k < 8; k++) begin
			add_byte((k % 2 == 0) ? 8'h00 : 8'hFF, k == 7, 1'b0);
		end
		for (int k = 0; k < 5; k++) begin
			add_byte(8'h00, k == 4, 1'b0);
		end

		n = 0;
		long_done = 1'b0;
		while (n < RandomBytes) begin
			if (!long_done && n >= 200) begin
				len = $urandom_range(260, 300);
				long_done = 1'b1;
			end else begin
				len = $urandom_range(1, 12);
			end
			for (int k = 0; k < len; k++) begin
				r = $urandom_range(0, 9);
				b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
				add_byte(b, k == len - 1, n == 320 || n == 560);
				n++;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (tx_bytes.size() != 0 || msg_if.valid || sums_pushed != sums_seen);
		repeat (16) @(posedge clk);

		while (expected_sums.size() > 0) begin
			report("checksum never produced", expected_sums.pop_front(), 'x);
		end

		$display("%0d bytes in %0d messages, %0d borrow folds, %0d position wraps",
			bytes_taken, msgs_closed, neg_folds, pos_wraps);
		$display("receiver held off %0d cycles once; input stalled %0d cycles in total",
			HoldCycles, in_stalls);
		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[three_term_recurrence_checksum_core.f]
sv/ttrc_pkg.sv
sv/ttrc_in_if.sv
sv/ttrc_out_if.sv
sv/ttrc_term.sv
sv/three_term_recurrence_checksum_core.sv
verif/tb.sv
